// ----- design/ssl_pkg.sv -----
// shared types, constants and keyword tables for the script source lexer
// no dependencies
package ssl_pkg;

   typedef enum logic [2:0] {
      M_IDLE, M_NUM, M_IDENT, M_STR, M_COMMENT, M_OP
   } mode_type;

   localparam logic [1:0] ST_TOKEN = 2'd0;
   localparam logic [1:0] ST_END   = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   localparam logic [2:0] E_NONE     = 3'd0;
   localparam logic [2:0] E_BAD_CHAR = 3'd1;
   localparam logic [2:0] E_DOT      = 3'd2;
   localparam logic [2:0] E_BAD_OP   = 3'd3;
   localparam logic [2:0] E_NL_STR   = 3'd4;
   localparam logic [2:0] E_OPEN_STR = 3'd5;

   localparam logic [5:0] K_LPAR = 6'd0,  K_RPAR = 6'd1,  K_SEMI = 6'd2,  K_COMMA = 6'd3;
   localparam logic [5:0] K_LBRACE = 6'd4, K_RBRACE = 6'd5, K_DOT = 6'd6, K_QUEST = 6'd7;
   localparam logic [5:0] K_COLON = 6'd8, K_XOR = 6'd9, K_REL = 6'd10, K_EQUALITY = 6'd11;
   localparam logic [5:0] K_ASSIGN = 6'd12, K_STAR = 6'd13, K_SLASH = 6'd14, K_PLUS = 6'd15;
   localparam logic [5:0] K_MINUS = 6'd16, K_INC = 6'd17, K_DEC = 6'd18, K_NOT = 6'd19;
   localparam logic [5:0] K_EQ = 6'd20, K_BAND = 6'd21, K_LAND = 6'd22, K_BOR = 6'd23;
   localparam logic [5:0] K_LOR = 6'd24, K_REM = 6'd25, K_NUM = 6'd26, K_NAME = 6'd27;
   localparam logic [5:0] K_STR = 6'd28, K_KW0 = 6'd29;

   localparam int NUM_KW = 12;
   localparam int MAX_RES = 4;

   // keyword text, right aligned in a 9 byte field
   localparam logic [71:0] KW_TEXT [NUM_KW] = '{
      72'("true"), 72'("false"), 72'("null"), 72'("undefined"), 72'("break"),
      72'("return"), 72'("new"), 72'("this"), 72'("continue"), 72'("throw"),
      72'("do"), 72'("while")
   };
   localparam logic [3:0] KW_LEN [NUM_KW] = '{
      4'd4, 4'd5, 4'd4, 4'd9, 4'd5, 4'd6, 4'd3, 4'd4, 4'd8, 4'd5, 4'd2, 4'd5
   };

   typedef struct packed {
      mode_type    mode;
      logic [15:0] token_start;
      logic [15:0] byte_offset;
      logic [15:0] line_count;
      logic [15:0] line_start;
      logic [15:0] token_line;
      logic [7:0]  op_first;
      logic [1:0]  op_run;
      logic [5:0]  op_kind;
      logic        dot_seen;
      logic        quote_kind;
      logic [11:0] kw_mask;
      logic [3:0]  ident_len;
      logic        held_valid;
      logic [5:0]  held_kind;
      logic [15:0] held_offset;
      logic [15:0] held_length;
      logic [15:0] held_line;
      logic [15:0] held_column;
      logic        held_break;
      logic        error_seen;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode: M_IDLE, token_start: 16'd0, byte_offset: 16'd0, line_count: 16'd1,
      line_start: 16'd0, token_line: 16'd1, op_first: 8'd0, op_run: 2'd0,
      op_kind: 6'd0, dot_seen: 1'b0, quote_kind: 1'b0, kw_mask: 12'hFFF,
      ident_len: 4'd0, held_valid: 1'b0, held_kind: 6'd0, held_offset: 16'd0,
      held_length: 16'd0, held_line: 16'd1, held_column: 16'd0, held_break: 1'b0,
      error_seen: 1'b0
   };

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  kind;
      logic [15:0] offset;
      logic [15:0] length;
      logic [15:0] line;
      logic [15:0] column;
      logic        brk;
      logic [2:0]  err;
      logic [7:0]  ch;
      logic        last;
   } res_type;

   typedef res_type [MAX_RES-1:0] res_arr_type;

endpackage

// ----- design/ssl_step.sv -----
// next state and result list for one source byte and end marker
// depends on ssl_pkg
module ssl_step import ssl_pkg::*; #(
   parameter logic [15:0] PosCap = 16'hFFFF
) (
   input  state_type        cur,
   input  logic [7:0]       data_byte,
   input  logic             has_byte,
   input  logic             end_of_input,
   output state_type        nxt,
   output res_arr_type      res,
   output logic [2:0]       res_count
);

   function automatic logic [15:0] pos_inc(input logic [15:0] v);
      return (v < PosCap) ? v + 16'd1 : PosCap;
   endfunction

   function automatic logic [15:0] col_of(input state_type s, input logic [15:0] at);
      return (at >= s.line_start) ? at - s.line_start : 16'd0;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_id_start(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
   endfunction

   function automatic void put(inout res_arr_type r, inout logic [2:0] n,
                               input res_type x);
      if (n < 3'(MAX_RES)) begin
         r[n[1:0]] = x;
         n = n + 3'd1;
      end
   endfunction

   function automatic void fail(inout state_type s, inout res_arr_type r, inout logic [2:0] n,
                                input logic [2:0] code, input logic [7:0] ch,
                                input logic [15:0] at, input logic [15:0] line);
      res_type x;
      x = '{status: ST_ERROR, kind: 6'd0, offset: at, length: 16'd0, line: line,
            column: col_of(s, at), brk: 1'b0, err: code, ch: ch, last: 1'b0};
      put(r, n, x);
      s.error_seen = 1'b1;
      s.held_valid = 1'b0;
      s.mode = M_IDLE;
   endfunction

   function automatic void emit_held(input state_type s, inout res_arr_type r,
                                     inout logic [2:0] n);
      res_type x;
      x = '{status: ST_TOKEN, kind: s.held_kind, offset: s.held_offset,
            length: s.held_length, line: s.held_line, column: s.held_column,
            brk: s.held_break, err: E_NONE, ch: 8'd0, last: 1'b0};
      if (s.held_valid) put(r, n, x);
   endfunction

   function automatic void push_tok(inout state_type s, inout res_arr_type r,
                                    inout logic [2:0] n, input logic [5:0] kind,
                                    input logic [15:0] len);
      emit_held(s, r, n);
      s.held_valid = 1'b1;
      s.held_kind = kind;
      s.held_offset = s.token_start;
      s.held_length = len;
      s.held_line = s.token_line;
      s.held_column = col_of(s, s.token_start);
      s.held_break = 1'b0;
      s.mode = M_IDLE;
   endfunction

   function automatic void kw_feed(inout state_type s, input logic [7:0] c);
      logic [71:0] sh;
      for (int i = 0; i < NUM_KW; i++) begin
         sh = KW_TEXT[i] >> (8 * (32'(KW_LEN[i]) - 1 - 32'(s.ident_len)));
         if (s.ident_len >= KW_LEN[i] || sh[7:0] != c) s.kw_mask[i] = 1'b0;
      end
      if (s.ident_len < 4'd15) s.ident_len = s.ident_len + 4'd1;
   endfunction

   function automatic logic [5:0] ident_kind(input state_type s);
      logic [5:0] k;
      logic       found;
      k = K_NAME;
      found = 1'b0;
      for (int i = 0; i < NUM_KW; i++) begin
         if (!found && s.kw_mask[i] && s.ident_len == KW_LEN[i]) begin
            k = K_KW0 + 6'(i);
            found = 1'b1;
         end
      end
      return k;
   endfunction

   function automatic logic op_cont(input logic [7:0] f, input logic [7:0] c);
      case (f)
         "&":     return c == "&";
         "|":     return c == "|";
         "+":     return c == "=" || c == "+";
         "-":     return c == "=" || c == "-";
         default: return c == "=";
      endcase
   endfunction

   function automatic logic [5:0] op_second(input logic [7:0] f, input logic [7:0] c);
      case (f)
         "<", ">": return K_REL;
         "+":      return (c == "+") ? K_INC : K_ASSIGN;
         "-":      return (c == "-") ? K_DEC : K_ASSIGN;
         "!", "=": return K_EQUALITY;
         "&":      return K_LAND;
         "|":      return K_LOR;
         default:  return K_ASSIGN;
      endcase
   endfunction

   function automatic void idle_byte(inout state_type s, inout res_arr_type r,
                                     inout logic [2:0] n, input logic [7:0] c);
      logic       single_hit;
      logic       op_hit;
      logic [5:0] k;
      single_hit = 1'b0;
      op_hit = 1'b0;
      k = 6'd0;
      if (c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == 8'h0D) begin
         if (c == 8'h0A) begin
            if (s.line_count < 16'hFFFF) s.line_count = s.line_count + 16'd1;
            s.line_start = pos_inc(s.byte_offset);
            if (s.held_valid) s.held_break = 1'b1;
         end
      end else begin
         s.token_start = s.byte_offset;
         s.token_line = s.line_count;
         case (c)
            "(": begin single_hit = 1'b1; k = K_LPAR; end
            ")": begin single_hit = 1'b1; k = K_RPAR; end
            ";": begin single_hit = 1'b1; k = K_SEMI; end
            ",": begin single_hit = 1'b1; k = K_COMMA; end
            "{": begin single_hit = 1'b1; k = K_LBRACE; end
            "}": begin single_hit = 1'b1; k = K_RBRACE; end
            ".": begin single_hit = 1'b1; k = K_DOT; end
            "?": begin single_hit = 1'b1; k = K_QUEST; end
            ":": begin single_hit = 1'b1; k = K_COLON; end
            "^": begin single_hit = 1'b1; k = K_XOR; end
            "<", ">": begin op_hit = 1'b1; k = K_REL; end
            "%": begin op_hit = 1'b1; k = K_REM; end
            "*": begin op_hit = 1'b1; k = K_STAR; end
            "/": begin op_hit = 1'b1; k = K_SLASH; end
            "+": begin op_hit = 1'b1; k = K_PLUS; end
            "-": begin op_hit = 1'b1; k = K_MINUS; end
            "!": begin op_hit = 1'b1; k = K_NOT; end
            "=": begin op_hit = 1'b1; k = K_EQ; end
            "&": begin op_hit = 1'b1; k = K_BAND; end
            "|": begin op_hit = 1'b1; k = K_BOR; end
            default: ;
         endcase
         if (single_hit) begin
            push_tok(s, r, n, k, 16'd1);
         end else if (op_hit) begin
            s.mode = M_OP;
            s.op_first = c;
            s.op_run = 2'd1;
            s.op_kind = k;
         end else if (is_digit(c)) begin
            s.mode = M_NUM;
            s.dot_seen = 1'b0;
         end else if (is_id_start(c)) begin
            s.mode = M_IDENT;
            s.kw_mask = 12'hFFF;
            s.ident_len = 4'd0;
            kw_feed(s, c);
         end else if (c == 8'h22 || c == 8'h27) begin
            s.mode = M_STR;
            s.quote_kind = (c == 8'h27);
         end else begin
            fail(s, r, n, E_BAD_CHAR, c, s.byte_offset, s.line_count);
         end
      end
   endfunction

   always_comb begin
      state_type   s;
      res_arr_type r;
      logic [2:0]  n;
      logic        do_idle;
      logic [15:0] run;
      logic [1:0]  most;
      logic [7:0]  q;
      res_type     e;
      s = cur;
      r = '0;
      n = 3'd0;
      do_idle = 1'b0;
      run = cur.byte_offset - cur.token_start;
      q = cur.quote_kind ? 8'h27 : 8'h22;
      most = 2'd2;
      e = '0;
      if (has_byte && !cur.error_seen) begin
         case (s.mode)
            M_NUM: begin
               if (is_digit(data_byte)) begin
               end else if (data_byte == ".") begin
                  if (s.dot_seen) fail(s, r, n, E_DOT, data_byte, s.byte_offset, s.line_count);
                  else s.dot_seen = 1'b1;
               end else begin
                  push_tok(s, r, n, K_NUM, run);
                  do_idle = 1'b1;
               end
            end
            M_IDENT: begin
               if (is_id_start(data_byte) || is_digit(data_byte)) begin
                  kw_feed(s, data_byte);
               end else begin
                  push_tok(s, r, n, ident_kind(s), run);
                  do_idle = 1'b1;
               end
            end
            M_STR: begin
               if (data_byte == q) begin
                  push_tok(s, r, n, K_STR, (run >= 16'd1) ? run - 16'd1 : 16'd0);
               end else if (data_byte == 8'h0A) begin
                  fail(s, r, n, E_NL_STR, data_byte, s.byte_offset, s.line_count);
               end
            end
            M_COMMENT: begin
               if (data_byte == 8'h0A) begin
                  s.mode = M_IDLE;
                  do_idle = 1'b1;
               end
            end
            M_OP: begin
               most = (s.op_first == "!" || s.op_first == "=") ? 2'd3 : 2'd2;
               if (s.op_run == 2'd1 && s.op_first == "/" && data_byte == "/") begin
                  s.mode = M_COMMENT;
               end else if (s.op_run == 2'd1 && (s.op_first == "+" || s.op_first == "-")
                            && is_digit(data_byte)) begin
                  s.mode = M_NUM;
                  s.dot_seen = 1'b0;
               end else if (op_cont(s.op_first, data_byte)) begin
                  if (s.op_run >= most) begin
                     fail(s, r, n, E_BAD_OP, data_byte, s.byte_offset, s.line_count);
                  end else begin
                     s.op_run = s.op_run + 2'd1;
                     if (s.op_run == 2'd2) s.op_kind = op_second(s.op_first, data_byte);
                  end
               end else begin
                  push_tok(s, r, n, s.op_kind, run);
                  do_idle = 1'b1;
               end
            end
            default: do_idle = 1'b1;
         endcase
         if (do_idle) idle_byte(s, r, n, data_byte);
         s.byte_offset = pos_inc(s.byte_offset);
      end
      if (end_of_input) begin
         run = s.byte_offset - s.token_start;
         if (!s.error_seen) begin
            case (s.mode)
               M_NUM:   push_tok(s, r, n, K_NUM, run);
               M_IDENT: push_tok(s, r, n, ident_kind(s), run);
               M_OP:    push_tok(s, r, n, s.op_kind, run);
               M_STR:   fail(s, r, n, E_OPEN_STR, s.quote_kind ? 8'h27 : 8'h22,
                             s.token_start, s.token_line);
               default: ;
            endcase
            if (!s.error_seen) emit_held(s, r, n);
         end
         e = '{status: ST_END, kind: 6'd0, offset: s.byte_offset, length: 16'd0,
               line: s.line_count, column: col_of(s, s.byte_offset), brk: 1'b0,
               err: E_NONE, ch: 8'd0, last: 1'b0};
         put(r, n, e);
         s = STATE_RESET;
      end
      if (n != 3'd0) r[2'(n - 3'd1)].last = 1'b1;
      nxt = s;
      res = r;
      res_count = n;
   end

endmodule

// ----- design/ssl_outbuf.sv -----
// result buffer: takes up to four results of one byte at once, hands them out one a beat
// depends on ssl_pkg
module ssl_outbuf import ssl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  res_arr_type load_res,
   input  logic [2:0]  load_count,
   output logic        can_load,
   output logic        out_valid,
   input  logic        out_ready,
   output res_type     out_res
);

   res_arr_type entries_ff, entries_in;
   logic [1:0]  head_ff, head_in;
   logic [2:0]  left_ff, left_in;
   logic        pop;

   assign out_valid = left_ff != 3'd0;
   assign out_res   = entries_ff[head_ff];
   assign pop       = out_valid && out_ready;
   // free in the same cycle as the last waiting beat goes
   assign can_load  = (left_ff == 3'd0) || (left_ff == 3'd1 && out_ready);

   always_comb begin
      entries_in = entries_ff;
      head_in    = head_ff;
      left_in    = left_ff;
      if (pop) begin
         head_in = head_ff + 2'd1;
         left_in = left_ff - 3'd1;
      end
      if (load) begin
         entries_in = load_res;
         head_in    = 2'd0;
         left_in    = load_count;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         head_ff <= 2'd0;
         left_ff <= 3'd0;
      end else begin
         head_ff <= head_in;
         left_ff <= left_in;
      end
   end

endmodule

// ----- design/script_source_lexer.sv -----
// top level of the streaming script source lexer
// depends on ssl_pkg, ssl_step and ssl_outbuf

// One source byte (or a bare end marker) is taken per beat on the req_ channel and the
// whole lexing step for it runs combinationally between the scanner state register and
// a four entry result buffer. A byte with no result, or one result that the rsp_ side
// takes at once, does not hold the next byte back, so plain text streams at one byte per
// cycle while rsp_ready stays high; a byte that yields n results (at most four, counting
// the end result) keeps req_ready low until n-1 of them have left. The last token is
// held inside until the next token or the end marker, so its break_after is known;
// last_result marks the final beat produced by one input beat. Offsets saturate at
// min(MAX_TEXT_BYTES-1, 65535). After an error all bytes are swallowed until end_of_input.
module script_source_lexer import ssl_pkg::*; #(
   parameter int MAX_TEXT_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_token_kind,
   output logic [15:0] rsp_start_offset,
   output logic [15:0] rsp_text_length,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_column_number,
   output logic        rsp_break_after,
   output logic [2:0]  rsp_error_code,
   output logic [7:0]  rsp_error_char,
   output logic        rsp_last_result
);

   // saturation point of every offset
   localparam logic [15:0] POS_CAP =
      (MAX_TEXT_BYTES - 1 < 65535) ? 16'(MAX_TEXT_BYTES - 1) : 16'hFFFF;

   state_type   state_ff, state_in;
   res_arr_type step_res;
   logic [2:0]  step_count;
   logic        accept;
   res_type     head;

   assign accept = req_valid && req_ready;

   // whole lexing step for the presented beat
   ssl_step #(.PosCap(POS_CAP)) u_step (
      .cur          (state_ff),
      .data_byte    (req_data_byte),
      .has_byte     (req_has_byte),
      .end_of_input (req_end_of_input),
      .nxt          (state_in),
      .res          (step_res),
      .res_count    (step_count)
   );

   // scanner state only moves on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // results of one accepted beat wait here until the consumer takes them
   ssl_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_res   (step_res),
      .load_count (step_count),
      .can_load   (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_res    (head)
   );

   assign rsp_status        = head.status;
   assign rsp_token_kind    = head.kind;
   assign rsp_start_offset  = head.offset;
   assign rsp_text_length   = head.length;
   assign rsp_line_number   = head.line;
   assign rsp_column_number = head.column;
   assign rsp_break_after   = head.brk;
   assign rsp_error_code    = head.err;
   assign rsp_error_char    = head.ch;
   assign rsp_last_result   = head.last;

endmodule
